// ===== sv/pmti_pkg.sv =====
package pmti_pkg;

    localparam int MAX_SIDES  = 16;
    localparam int MAX_SUBDIV = 255;

    localparam int SIDES_W    = 5;
    localparam int SUBDIV_W   = 8;
    localparam int VTX_W      = 20;
    localparam int OUT_W      = 19;
    localparam int SIDE_IDX_W = $clog2(MAX_SIDES);
    localparam int ADDR_W     = 3;
    localparam int DATA_W     = 32;
    localparam int REG_IDX_W  = ADDR_W - 2;

    localparam logic [REG_IDX_W-1:0] REG_SIDE_COUNT   = REG_IDX_W'(0);
    localparam logic [REG_IDX_W-1:0] REG_SUBDIVISIONS = REG_IDX_W'(1);

    localparam logic [SIDES_W-1:0]  SIDES_RESET  = SIDES_W'(4);
    localparam logic [SUBDIV_W-1:0] SUBDIV_RESET = SUBDIV_W'(1);
    localparam logic [SIDES_W-1:0]  MIN_SIDES    = SIDES_W'(3);
    localparam logic [SIDES_W-1:0]  QUAD_SIDES   = SIDES_W'(4);

    typedef enum logic [1:0] {
        MODE_TRI,
        MODE_QUAD,
        MODE_RING
    } mesh_mode_t;

    typedef struct packed {
        mesh_mode_t          mode;
        logic [SIDES_W-1:0]  sides;
        logic [SUBDIV_W-1:0] subdiv;
        logic                restart;
    } cfg_t;

    typedef struct packed {
        logic [SUBDIV_W-1:0]   layer_count;
        logic [SIDE_IDX_W-1:0] side_index;
        logic [SUBDIV_W-1:0]   position_count;
        logic [VTX_W-1:0]      inner_vertex;
        logic [VTX_W-1:0]      outer_vertex;
        logic [VTX_W-1:0]      inner_ring_start;
        logic [VTX_W-1:0]      outer_ring_start;
        logic                  second_half;
    } seq_state_t;

    typedef struct packed {
        logic [OUT_W-1:0] vertex_a;
        logic [OUT_W-1:0] vertex_b;
        logic [OUT_W-1:0] vertex_c;
        logic             last_triangle;
    } result_t;

    function automatic seq_state_t seq_reset();
        seq_state_t s;
        s.layer_count      = '0;
        s.side_index       = '0;
        s.position_count   = '0;
        s.inner_vertex     = '0;
        s.outer_vertex     = VTX_W'(1);
        s.inner_ring_start = '0;
        s.outer_ring_start = VTX_W'(1);
        s.second_half      = 1'b0;
        return s;
    endfunction

endpackage

// ===== sv/pmti_cfg.sv =====
module pmti_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [pmti_pkg::ADDR_W-1:0]    paddr,
    input  logic [pmti_pkg::DATA_W-1:0]    pwdata,
    output logic [pmti_pkg::DATA_W-1:0]    prdata,
    output logic                           pready,
    output pmti_pkg::cfg_t                 cfg
);
    import pmti_pkg::*;

    logic [SIDES_W-1:0]   side_count_reg;
    logic [SUBDIV_W-1:0]  subdivisions_reg;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_count_reg   <= SIDES_RESET;
            subdivisions_reg <= SUBDIV_RESET;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_SIDE_COUNT:   side_count_reg   <= pwdata[SIDES_W-1:0];
                REG_SUBDIVISIONS: subdivisions_reg <= pwdata[SUBDIV_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_SIDE_COUNT:   prdata = DATA_W'(side_count_reg);
            REG_SUBDIVISIONS: prdata = DATA_W'(subdivisions_reg);
            default:          prdata = '0;
        endcase
    end

    // clamp to the supported range and derive the mesh mode
    always_comb
    begin
        if (side_count_reg < MIN_SIDES)
            cfg.sides = MIN_SIDES;
        else if (32'(side_count_reg) > MAX_SIDES)
            cfg.sides = SIDES_W'(MAX_SIDES);
        else
            cfg.sides = side_count_reg;

        if (subdivisions_reg == '0)
            cfg.subdiv = SUBDIV_W'(1);
        else if (32'(subdivisions_reg) > MAX_SUBDIV)
            cfg.subdiv = SUBDIV_W'(MAX_SUBDIV);
        else
            cfg.subdiv = subdivisions_reg;

        if (cfg.sides == MIN_SIDES)
            cfg.mode = MODE_TRI;
        else if (cfg.sides == QUAD_SIDES)
            cfg.mode = MODE_QUAD;
        else
            cfg.mode = MODE_RING;

        // any register write starts the mesh over
        cfg.restart = wr_en;
    end

endmodule

// ===== sv/pmti_gen.sv =====
module pmti_gen (
    input  logic                clk,
    input  logic                rst_n,
    input  pmti_pkg::cfg_t      cfg,
    input  logic                accept,
    input  logic                restart,
    output pmti_pkg::result_t   res
);
    import pmti_pkg::*;

    seq_state_t             state_reg;
    seq_state_t             s;
    seq_state_t             state_next;
    logic [SUBDIV_W-1:0]    r;
    logic [SIDES_W-1:0]     n;
    logic [VTX_W-1:0]       va;
    logic [VTX_W-1:0]       vb;
    logic [VTX_W-1:0]       vc;
    logic                   last;
    logic [VTX_W-1:0]       pos_v;
    logic [VTX_W-1:0]       r1_v;
    logic [SUBDIV_W:0]      pos_inc;
    logic [SUBDIV_W:0]      layer_inc;
    logic [2*SUBDIV_W:0]    qrow;
    logic [VTX_W-1:0]       qidx;
    logic [SIDES_W-1:0]     side_inc;
    logic                   wrap;

    assign r = cfg.subdiv;
    assign n = cfg.sides;

    always_comb
    begin
        s          = restart ? seq_reset() : state_reg;
        state_next = s;
        va         = '0;
        vb         = '0;
        vc         = '0;
        last       = 1'b0;
        pos_v      = VTX_W'(s.position_count);
        r1_v       = VTX_W'(r) + VTX_W'(1);
        pos_inc    = {1'b0, s.position_count} + (SUBDIV_W+1)'(1);
        layer_inc  = {1'b0, s.layer_count} + (SUBDIV_W+1)'(1);
        qrow       = (2*SUBDIV_W+1)'(s.layer_count)
                     * ((2*SUBDIV_W+1)'(r) + (2*SUBDIV_W+1)'(1));
        qidx       = VTX_W'(qrow) + pos_v;
        side_inc   = SIDES_W'(s.side_index) + SIDES_W'(1);
        // closing triangle of a ring reaches back to the ring's first vertex
        wrap       = (SIDES_W'(s.side_index) == n - SIDES_W'(1))
                     && (s.position_count == s.layer_count);

        unique case (cfg.mode)
            MODE_TRI:
            begin
                if (s.position_count < s.layer_count)
                begin
                    if (!s.second_half)
                    begin
                        va = s.outer_vertex + pos_v;
                        vb = s.outer_vertex + pos_v + VTX_W'(1);
                        vc = s.inner_vertex + pos_v;
                        state_next.second_half = 1'b1;
                    end
                    else
                    begin
                        va = s.outer_vertex + pos_v + VTX_W'(1);
                        vb = s.inner_vertex + pos_v + VTX_W'(1);
                        vc = s.inner_vertex + pos_v;
                        state_next.second_half    = 1'b0;
                        state_next.position_count = pos_inc[SUBDIV_W-1:0];
                    end
                end
                else
                begin
                    // row closes with a single upright triangle
                    va = s.outer_vertex + pos_v;
                    vb = s.outer_vertex + pos_v + VTX_W'(1);
                    vc = s.inner_vertex + pos_v;
                    state_next.inner_vertex   = s.outer_vertex;
                    state_next.outer_vertex   = s.outer_vertex + pos_v + VTX_W'(2);
                    state_next.layer_count    = layer_inc[SUBDIV_W-1:0];
                    state_next.position_count = '0;
                    state_next.second_half    = 1'b0;
                    last = layer_inc >= {1'b0, r};
                end
            end
            MODE_QUAD:
            begin
                if (!s.second_half)
                begin
                    va = qidx;
                    vb = qidx + r1_v;
                    vc = qidx + VTX_W'(1);
                    state_next.second_half = 1'b1;
                end
                else
                begin
                    va = qidx + VTX_W'(1);
                    vb = qidx + r1_v;
                    vc = qidx + r1_v + VTX_W'(1);
                    state_next.second_half = 1'b0;
                    if (pos_inc >= {1'b0, r})
                    begin
                        state_next.position_count = '0;
                        state_next.layer_count    = layer_inc[SUBDIV_W-1:0];
                        last = layer_inc >= {1'b0, r};
                    end
                    else
                    begin
                        state_next.position_count = pos_inc[SUBDIV_W-1:0];
                    end
                end
            end
            MODE_RING:
            begin
                if (!s.second_half)
                begin
                    va = s.inner_vertex;
                    vb = s.outer_vertex;
                    vc = wrap ? s.outer_ring_start : s.outer_vertex + VTX_W'(1);
                    state_next.outer_vertex = s.outer_vertex + VTX_W'(1);
                    if (pos_inc < layer_inc)
                    begin
                        state_next.position_count = pos_inc[SUBDIV_W-1:0];
                        state_next.second_half    = 1'b1;
                    end
                    else
                    begin
                        state_next.position_count = '0;
                        if (side_inc < n)
                        begin
                            state_next.side_index = side_inc[SIDE_IDX_W-1:0];
                        end
                        else
                        begin
                            // ring complete: step outwards
                            state_next.side_index       = '0;
                            state_next.inner_ring_start = s.outer_ring_start;
                            state_next.inner_vertex     = s.outer_ring_start;
                            state_next.outer_ring_start = s.outer_vertex + VTX_W'(1);
                            state_next.layer_count      = layer_inc[SUBDIV_W-1:0];
                            last = layer_inc >= {1'b0, r};
                        end
                    end
                end
                else
                begin
                    va = s.inner_vertex;
                    vb = s.outer_vertex;
                    vc = wrap ? s.inner_ring_start : s.inner_vertex + VTX_W'(1);
                    state_next.inner_vertex = vc;
                    state_next.second_half  = 1'b0;
                end
            end
            default:
            begin
                state_next = s;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= seq_reset();
        else if (cfg.restart)
            state_reg <= seq_reset();
        else if (accept)
            state_reg <= last ? seq_reset() : state_next;
    end

    assign res.vertex_a      = OUT_W'(va);
    assign res.vertex_b      = OUT_W'(vb);
    assign res.vertex_c      = OUT_W'(vc);
    assign res.last_triangle = last;

    a_layer_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.layer_count < cfg.subdiv)
        else $error("layer count reached the resolution without restart");

    a_ring_pos_in_side: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg.mode == MODE_RING) |-> state_reg.position_count <= state_reg.layer_count)
        else $error("ring position beyond side length");

    a_ring_side_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg.mode == MODE_RING) |-> SIDES_W'(state_reg.side_index) < cfg.sides)
        else $error("side index beyond side count");

    a_tri_half_in_row: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg.mode == MODE_TRI && state_reg.second_half)
            |-> state_reg.position_count < state_reg.layer_count)
        else $error("second half of a row cell past the row end");

endmodule

// ===== sv/pmti_out.sv =====
module pmti_out (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    output logic                         accept,
    input  pmti_pkg::result_t            res,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [pmti_pkg::OUT_W-1:0]   vertex_a,
    output logic [pmti_pkg::OUT_W-1:0]   vertex_b,
    output logic [pmti_pkg::OUT_W-1:0]   vertex_c,
    output logic                         last_triangle
);
    import pmti_pkg::*;

    logic    valid_reg;
    result_t res_reg;

    // a held word only blocks the input while the far side stalls
    assign in_stall = valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (accept)
            valid_reg <= 1'b1;
        else if (!out_stall)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            res_reg <= res;
    end

    assign out_valid     = valid_reg;
    assign vertex_a      = res_reg.vertex_a;
    assign vertex_b      = res_reg.vertex_b;
    assign vertex_c      = res_reg.vertex_c;
    assign last_triangle = res_reg.last_triangle;

endmodule

// ===== sv/patch_mesh_triangle_indices_unit.sv =====
// output: a triangle word appears in the cycle after its input word is taken
// throughput: one triangle per cycle while the receiver does not stall, as the
// sequence state steps once for every input word taken into the output register
// reset: side count 4, subdivisions 1, mesh sequence at its first triangle,
// output register empty
module patch_mesh_triangle_indices_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [pmti_pkg::ADDR_W-1:0]    paddr,
    input  logic [pmti_pkg::DATA_W-1:0]    pwdata,
    output logic [pmti_pkg::DATA_W-1:0]    prdata,
    output logic                           pready,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           restart,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [pmti_pkg::OUT_W-1:0]     vertex_a,
    output logic [pmti_pkg::OUT_W-1:0]     vertex_b,
    output logic [pmti_pkg::OUT_W-1:0]     vertex_c,
    output logic                           last_triangle
);
    import pmti_pkg::*;

    cfg_t    cfg;
    result_t res;
    logic    accept;

    pmti_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pmti_gen u_gen (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .accept  (accept),
        .restart (restart),
        .res     (res)
    );

    pmti_out u_out (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .accept        (accept),
        .res           (res),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .vertex_a      (vertex_a),
        .vertex_b      (vertex_b),
        .vertex_c      (vertex_c),
        .last_triangle (last_triangle)
    );

endmodule

// ===== tb/tb_patch_mesh_triangle_indices_unit.sv =====
module tb_patch_mesh_triangle_indices_unit;

    import pmti_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 200;
    localparam int RANDOM_ITEMS = 1800;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [ADDR_W-1:0]     paddr;
    logic [DATA_W-1:0]     pwdata;
    logic [DATA_W-1:0]     prdata;
    logic                  pready;
    logic                  in_valid;
    logic                  in_stall;
    logic                  restart;
    logic                  out_valid;
    logic                  out_stall;
    logic [OUT_W-1:0]      vertex_a;
    logic [OUT_W-1:0]      vertex_b;
    logic [OUT_W-1:0]      vertex_c;
    logic                  last_triangle;

    // predictor copy of the registers and the mesh walk
    logic [SIDES_W-1:0]    cfg_sides;
    logic [SUBDIV_W-1:0]   cfg_subdiv;
    int                    row_count;
    int                    side_pos;
    int                    col_count;
    int                    inner_v;
    int                    outer_v;
    int                    inner_first;
    int                    outer_first;
    bit                    upper_half;

    // newest at the front, oldest at the back
    result_t               pending_triangles[$];

    int                    err_count = 0;
    int                    cycle_count = 0;
    int                    words_sent = 0;
    int                    triangles_checked = 0;
    int                    meshes_closed = 0;
    int                    phase_count = 0;
    int                    burst_left = 0;
    bit                    gaps_on = 1'b0;
    int                    stall_mode = 0;
    bit                    hold_request = 1'b0;
    int                    hold_left = 0;
    int                    stall_tick = 0;

    patch_mesh_triangle_indices_unit uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .restart       (restart),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .vertex_a      (vertex_a),
        .vertex_b      (vertex_b),
        .vertex_c      (vertex_c),
        .last_triangle (last_triangle)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // receiver stall pattern, with a long hold-off on request
    always @(posedge clk)
    begin
        stall_tick++;
        if (hold_request)
        begin
            hold_left = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            case (stall_mode)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 2) == 0);
                2: out_stall <= ((stall_tick % 7) < 3);
                default: out_stall <= ($urandom_range(0, 2) != 0);
            endcase
        end
    end

    always @(posedge clk)
    begin
        result_t exp_tri;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_triangles.size() == 0)
            begin
                $error("triangle word with none expected");
                err_count++;
            end
            else
            begin
                exp_tri = pending_triangles.pop_back();
                triangles_checked++;
                if (exp_tri.last_triangle)
                    meshes_closed++;
                if (vertex_a !== exp_tri.vertex_a)
                begin
                    $error("vertex_a: expected %0d, got %0d", exp_tri.vertex_a, vertex_a);
                    err_count++;
                end
                if (vertex_b !== exp_tri.vertex_b)
                begin
                    $error("vertex_b: expected %0d, got %0d", exp_tri.vertex_b, vertex_b);
                    err_count++;
                end
                if (vertex_c !== exp_tri.vertex_c)
                begin
                    $error("vertex_c: expected %0d, got %0d", exp_tri.vertex_c, vertex_c);
                    err_count++;
                end
                if (last_triangle !== exp_tri.last_triangle)
                begin
                    $error("last_triangle: expected %0b, got %0b",
                           exp_tri.last_triangle, last_triangle);
                    err_count++;
                end
            end
        end
    end

    function automatic void mesh_rewind();
        row_count   = 0;
        side_pos    = 0;
        col_count   = 0;
        inner_v     = 0;
        outer_v     = 1;
        inner_first = 0;
        outer_first = 1;
        upper_half  = 1'b0;
    endfunction

    function automatic result_t next_triangle(input logic rewind);
        int          n;
        int          r;
        int          i;
        int          j;
        int          idx;
        int          ring;
        int          a;
        int          b;
        int          c;
        logic        wrap;
        logic        is_last;
        result_t     tri_out;
        n = int'(cfg_sides);
        if (n < int'(MIN_SIDES))
            n = int'(MIN_SIDES);
        else if (n > MAX_SIDES)
            n = MAX_SIDES;
        r = int'(cfg_subdiv);
        if (r == 0)
            r = 1;
        else if (r > MAX_SUBDIV)
            r = MAX_SUBDIV;
        if (rewind)
            mesh_rewind();
        is_last = 1'b0;
        a = 0;
        b = 0;
        c = 0;
        if (n == 3)
        begin
            i = row_count;
            j = col_count;
            if (j < i)
            begin
                if (!upper_half)
                begin
                    a = outer_v + j;
                    b = outer_v + j + 1;
                    c = inner_v + j;
                    upper_half = 1'b1;
                end
                else
                begin
                    a = outer_v + j + 1;
                    b = inner_v + j + 1;
                    c = inner_v + j;
                    upper_half = 1'b0;
                    col_count = j + 1;
                end
            end
            else
            begin
                // closing triangle of the row, next row starts after it
                a = outer_v + i;
                b = outer_v + i + 1;
                c = inner_v + i;
                inner_v = outer_v;
                outer_v = outer_v + i + 2;
                row_count = i + 1;
                col_count = 0;
                upper_half = 1'b0;
                is_last = (i + 1 >= r);
            end
        end
        else if (n == 4)
        begin
            idx = row_count * (r + 1) + col_count;
            if (!upper_half)
            begin
                a = idx;
                b = idx + r + 1;
                c = idx + 1;
                upper_half = 1'b1;
            end
            else
            begin
                a = idx + 1;
                b = idx + r + 1;
                c = idx + r + 2;
                upper_half = 1'b0;
                if (col_count + 1 >= r)
                begin
                    col_count = 0;
                    row_count = row_count + 1;
                end
                else
                    col_count = col_count + 1;
                is_last = (row_count >= r);
            end
        end
        else
        begin
            ring = row_count + 1;
            wrap = (side_pos == n - 1) && (col_count == ring - 1);
            if (!upper_half)
            begin
                a = inner_v;
                b = outer_v;
                c = wrap ? outer_first : outer_v + 1;
                outer_v = outer_v + 1;
                if (col_count + 1 < ring)
                begin
                    col_count = col_count + 1;
                    upper_half = 1'b1;
                end
                else
                begin
                    col_count = 0;
                    if (side_pos + 1 < n)
                        side_pos = side_pos + 1;
                    else
                    begin
                        // ring closed, it becomes the inner ring of the next one
                        side_pos = 0;
                        inner_first = outer_first;
                        inner_v = outer_first;
                        outer_first = outer_v;
                        row_count = row_count + 1;
                        is_last = (ring >= r);
                    end
                end
            end
            else
            begin
                a = inner_v;
                b = outer_v;
                c = wrap ? inner_first : inner_v + 1;
                inner_v = c;
                upper_half = 1'b0;
            end
        end
        if (is_last)
            mesh_rewind();
        tri_out.vertex_a = OUT_W'(a);
        tri_out.vertex_b = OUT_W'(b);
        tri_out.vertex_c = OUT_W'(c);
        tri_out.last_triangle = is_last;
        return tri_out;
    endfunction

    task automatic send_word(input logic rs);
        in_valid <= 1'b1;
        restart  <= rs;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_triangles.push_front(next_triangle(rs));
        words_sent++;
    endtask

    task automatic offer_word(input logic rs);
        if (gaps_on && burst_left <= 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        send_word(rs);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_triangles.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic reg_write(input logic [REG_IDX_W-1:0] idx, input int value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= DATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_SIDE_COUNT)
            cfg_sides = SIDES_W'(value);
        else
            cfg_subdiv = SUBDIV_W'(value);
        mesh_rewind();
    endtask

    task automatic set_mesh(input int sides, input int subdiv);
        reg_write(REG_SIDE_COUNT, sides);
        reg_write(REG_SUBDIVISIONS, subdiv);
    endtask

    task automatic test_reset_config();
        stall_mode = 1;
        gaps_on = 1'b0;
        send_word(1'b1);
        send_word(1'b0);
        send_word(1'b0);
        send_word(1'b1);
        send_word(1'b0);
        wait_idle();
    endtask

    task automatic test_config_extremes();
        int k;
        // zero subdivisions and a side count below three
        set_mesh(0, 0);
        send_word(1'b0);
        send_word(1'b0);
        wait_idle();
        set_mesh(2, 2);
        for (k = 0; k < 5; k++)
            send_word(1'b0);
        wait_idle();
        set_mesh(31, 1);
        send_word(1'b0);
        send_word(1'b0);
        wait_idle();
        set_mesh(17, 255);
        for (k = 0; k < 3; k++)
            send_word(1'b0);
        wait_idle();
        set_mesh(MAX_SIDES, 255);
        send_word(1'b1);
        send_word(1'b0);
        wait_idle();
        set_mesh(5, 2);
        for (k = 0; k < 5; k++)
            send_word(1'b0);
        wait_idle();
    endtask

    task automatic test_output_hold();
        int k;
        set_mesh(6, 3);
        stall_mode = 0;
        gaps_on = 1'b0;
        hold_request = 1'b1;
        for (k = 0; k < 40; k++)
            send_word(k == 0);
        wait_idle();
    endtask

    task automatic test_random_meshes();
        int target;
        int sides;
        int subdiv;
        int sel;
        int n_words;
        int k;
        target = words_sent + RANDOM_ITEMS;
        while (words_sent < target)
        begin
            sel = $urandom_range(0, 9);
            if (sel == 0)
                sides = $urandom_range(0, 31);
            else if (sel <= 3)
                sides = 3;
            else if (sel <= 5)
                sides = 4;
            else
                sides = $urandom_range(5, MAX_SIDES);
            sel = $urandom_range(0, 19);
            if (sel == 0)
                subdiv = 0;
            else if (sel == 1)
                subdiv = $urandom_range(100, 255);
            else
                subdiv = $urandom_range(1, 5);
            case ($urandom_range(0, 2))
                0: set_mesh(sides, subdiv);
                1: reg_write(REG_SIDE_COUNT, sides);
                default: reg_write(REG_SUBDIVISIONS, subdiv);
            endcase
            stall_mode = $urandom_range(0, 3);
            gaps_on = ($urandom_range(0, 3) != 0);
            burst_left = 0;
            n_words = $urandom_range(30, 120);
            for (k = 0; k < n_words; k++)
                offer_word($urandom_range(0, 39) == 0);
            wait_idle();
            phase_count++;
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        in_valid  = 1'b0;
        restart   = 1'b0;
        cfg_sides  = SIDES_RESET;
        cfg_subdiv = SUBDIV_RESET;
        mesh_rewind();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_config();
        test_config_extremes();
        test_output_hold();
        test_random_meshes();

        wait_idle();
        repeat (5) @(posedge clk);
        $display("sent %0d words, checked %0d triangles, %0d meshes closed",
                 words_sent, triangles_checked, meshes_closed);
        $display("%0d random mesh settings, one long output hold-off", phase_count);
        if (err_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== patch_mesh_triangle_indices_unit.f =====
sv/pmti_pkg.sv
sv/pmti_cfg.sv
sv/pmti_gen.sv
sv/pmti_out.sv
sv/patch_mesh_triangle_indices_unit.sv
tb/tb_patch_mesh_triangle_indices_unit.sv
